// ===== rtl/hmeg_pkg.sv =====
// Shared types and constants of the Heisenberg matrix element generator.
package hmeg_pkg;

  localparam int StateW   = 16;
  localparam int SiteW    = 4;
  localparam int CoupW    = 16;
  localparam int DeltaW   = 17;
  localparam int SiteCntW = 5;
  localparam int BondCntW = 6;
  localparam int SlotW    = 5;
  localparam int CfgW     = 6;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_GEN  = 1'b1
  } req_e;

  typedef enum logic {
    REG_SITE_COUNT = 1'b0,
    REG_BOND_COUNT = 1'b1
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic load_we;
    logic gen_start;
    logic rd_en;
    logic eval;
    logic second;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                need_second;
    logic [BondCntW-1:0] bond_cnt;
  } status_t;

endpackage

// ===== rtl/hmeg_ctrl.sv =====
// Sequencer that walks the bond table for one generate item.
module hmeg_ctrl #(
  parameter int MAX_BONDS = 32,
  localparam int AddrW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                req_type_i,
  input  hmeg_pkg::status_t   status_i,
  output hmeg_pkg::cmd_t      cmd_o,
  output logic [AddrW-1:0]    addr_o,
  output logic                busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SECOND
  } state_e;

  state_e                        state_q;
  logic [hmeg_pkg::BondCntW-1:0] idx_q;
  logic                          rv_q;   // read register holds a fetched entry
  logic                          issue;
  logic                          accept;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);
  assign issue  = (state_q == ST_WALK) && (idx_q < status_i.bond_cnt);
  assign addr_o = idx_q[AddrW-1:0];

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_we   = accept && (req_type_i == hmeg_pkg::REQ_LOAD);
    cmd_o.gen_start = accept && (req_type_i == hmeg_pkg::REQ_GEN);
    cmd_o.rd_en     = issue;
    cmd_o.eval      = (state_q == ST_WALK) && rv_q;
    cmd_o.second    = (state_q == ST_SECOND);
    cmd_o.flush     = (state_q == ST_WALK) && !rv_q && !issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == hmeg_pkg::REQ_GEN)) begin
            state_q <= ST_WALK;
            idx_q   <= '0;
            rv_q    <= 1'b0;
          end
        end
        ST_WALK: begin
          // entry held in the read register is evaluated while the next one is read
          if (rv_q && status_i.need_second) begin
            state_q <= ST_SECOND;
          end else if (!rv_q && !issue) begin
            state_q <= ST_IDLE;
          end
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          rv_q <= issue;
        end
        ST_SECOND: begin
          state_q <= ST_WALK;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hmeg_dp.sv =====
// Datapath: configuration, bond table, element evaluation and result staging.
module hmeg_dp #(
  parameter int MAX_SITES = 16,
  parameter int MAX_BONDS = 32,
  localparam int AddrW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hmeg_pkg::cmd_t                      cmd_i,
  input  logic [AddrW-1:0]                    addr_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hmeg_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic [hmeg_pkg::StateW-1:0]         basis_state_i,
  input  logic [hmeg_pkg::SiteW-1:0]          site_i,
  input  logic [hmeg_pkg::SlotW-1:0]          bond_slot_i,
  input  logic [hmeg_pkg::SiteW-1:0]          bond_first_site_i,
  input  logic [hmeg_pkg::SiteW-1:0]          bond_second_site_i,
  input  logic signed [hmeg_pkg::CoupW-1:0]   bond_coupling_i,
  output hmeg_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  output logic [hmeg_pkg::StateW-1:0]         row_o,
  output logic [hmeg_pkg::StateW-1:0]         column_o,
  output logic signed [hmeg_pkg::DeltaW-1:0]  delta_o,
  output logic                                last_o
);

  localparam int SiteLim = (MAX_SITES < hmeg_pkg::StateW) ? MAX_SITES : hmeg_pkg::StateW;

  typedef struct packed {
    logic [hmeg_pkg::SiteW-1:0] first;
    logic [hmeg_pkg::SiteW-1:0] second;
    logic [hmeg_pkg::CoupW-1:0] coup;
  } entry_t;

  logic [hmeg_pkg::SiteCntW-1:0]     site_cnt_q;
  logic [hmeg_pkg::BondCntW-1:0]     bond_cnt_q;
  logic [hmeg_pkg::BondCntW-1:0]     bond_cnt_lim;
  logic [hmeg_pkg::SiteCntW-1:0]     site_n;
  logic [hmeg_pkg::StateW-1:0]       mask_d;

  entry_t                            mem [MAX_BONDS];
  entry_t                            rd_q;

  logic [hmeg_pkg::StateW-1:0]       st_q;
  logic [hmeg_pkg::StateW-1:0]       mask_q;
  logic [hmeg_pkg::SiteW-1:0]        site_q;
  logic signed [hmeg_pkg::DeltaW-1:0] neg_q;

  logic                              match;
  logic                              differ;
  logic                              gen_new;
  logic [hmeg_pkg::StateW-1:0]       flip;
  logic [hmeg_pkg::StateW-1:0]       new_col;
  logic signed [hmeg_pkg::DeltaW-1:0] j_ext;
  logic signed [hmeg_pkg::DeltaW-1:0] new_delta;

  logic                              pend_valid_q;
  logic [hmeg_pkg::StateW-1:0]       pend_col_q;
  logic signed [hmeg_pkg::DeltaW-1:0] pend_delta_q;
  logic                              out_valid_q;
  logic [hmeg_pkg::StateW-1:0]       row_q;
  logic [hmeg_pkg::StateW-1:0]       col_q;
  logic signed [hmeg_pkg::DeltaW-1:0] delta_q;
  logic                              last_q;
  logic                              emit;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_cnt_q <= hmeg_pkg::SiteCntW'(16);
      bond_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (hmeg_pkg::reg_e'(cfg_idx_i))
        hmeg_pkg::REG_SITE_COUNT: site_cnt_q <= cfg_wdata_i[hmeg_pkg::SiteCntW-1:0];
        hmeg_pkg::REG_BOND_COUNT: bond_cnt_q <= cfg_wdata_i[hmeg_pkg::BondCntW-1:0];
        default: ;
      endcase
    end
  end

  assign bond_cnt_lim = (int'(bond_cnt_q) > MAX_BONDS) ? hmeg_pkg::BondCntW'(MAX_BONDS)
                                                       : bond_cnt_q;
  assign site_n       = (int'(site_cnt_q) > SiteLim) ? hmeg_pkg::SiteCntW'(SiteLim)
                                                     : site_cnt_q;

  always_comb begin
    for (int b = 0; b < hmeg_pkg::StateW; b++) begin
      mask_d[b] = (b < int'(site_n));
    end
  end

  assign status_o.bond_cnt    = bond_cnt_lim;
  assign status_o.need_second = match && differ;

  // bond table, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && (int'(bond_slot_i) < MAX_BONDS)) begin
      mem[bond_slot_i[AddrW-1:0]] <= '{first:  bond_first_site_i,
                                       second: bond_second_site_i,
                                       coup:   bond_coupling_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[addr_i];
    end
  end

  // element evaluation
  assign match   = (rd_q.first == site_q);
  assign differ  = (st_q[site_q] != st_q[rd_q.second]);
  assign flip    = (st_q ^ (hmeg_pkg::StateW'(1) << site_q)
                         ^ (hmeg_pkg::StateW'(1) << rd_q.second)) & mask_q;
  assign j_ext   = {rd_q.coup[hmeg_pkg::CoupW-1], rd_q.coup};
  assign gen_new = (cmd_i.eval && match) || cmd_i.second;

  always_comb begin
    if (cmd_i.second) begin
      new_col   = st_q;
      new_delta = neg_q;
    end else if (differ) begin
      new_col   = flip;
      new_delta = {rd_q.coup, 1'b0};
    end else begin
      new_col   = st_q;
      new_delta = j_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_start) begin
      st_q   <= basis_state_i & mask_d;
      mask_q <= mask_d;
      site_q <= site_i;
    end
    if (cmd_i.eval) begin
      neg_q <= -j_ext;
    end
  end

  // one result is held back until it is known whether another follows
  assign emit = pend_valid_q && (gen_new || cmd_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= emit;
      if (gen_new) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      row_q   <= st_q;
      col_q   <= pend_col_q;
      delta_q <= pend_delta_q;
      last_q  <= cmd_i.flush;
    end
    if (gen_new) begin
      pend_col_q   <= new_col;
      pend_delta_q <= new_delta;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign column_o    = col_q;
  assign delta_o     = delta_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/heisenberg_matrix_element_generator.sv =====
// Top level of the Heisenberg matrix element generator.
// An item is taken when start_i is high and busy_o is low. A load item writes
// one bond table entry in its accept cycle and leaves busy_o low. A generate
// item walks bond_count table entries (at most MAX_BONDS) through the table's
// registered read port, one entry a cycle save where the walk pauses for the
// second result of a matching bond whose spin bits differ (such a bond yields
// two results); busy_o stays high until the walk ends. Results appear on
// out_valid_o for one cycle each and cannot be held off by the receiver; the
// final one, marked by last_o, is on the ports in the first cycle with busy_o
// low, and a generate item with no matching bond gives no result.
module heisenberg_matrix_element_generator #(
  parameter int MAX_SITES = 16,
  parameter int MAX_BONDS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                req_type_i,
  input  logic [hmeg_pkg::StateW-1:0]         basis_state_i,
  input  logic [hmeg_pkg::SiteW-1:0]          site_i,
  input  logic [hmeg_pkg::SlotW-1:0]          bond_slot_i,
  input  logic [hmeg_pkg::SiteW-1:0]          bond_first_site_i,
  input  logic [hmeg_pkg::SiteW-1:0]          bond_second_site_i,
  input  logic signed [hmeg_pkg::CoupW-1:0]   bond_coupling_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hmeg_pkg::CfgW-1:0]           cfg_wdata_i,
  output logic                                out_valid_o,
  output logic [hmeg_pkg::StateW-1:0]         row_o,
  output logic [hmeg_pkg::StateW-1:0]         column_o,
  output logic signed [hmeg_pkg::DeltaW-1:0]  delta_o,
  output logic                                last_o
);

  localparam int AddrW = (MAX_BONDS > 1) ? $clog2(MAX_BONDS) : 1;

  hmeg_pkg::cmd_t    cmd;
  hmeg_pkg::status_t status;
  logic [AddrW-1:0]  addr;

  hmeg_ctrl #(
    .MAX_BONDS (MAX_BONDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .busy_o     (busy_o)
  );

  hmeg_dp #(
    .MAX_SITES (MAX_SITES),
    .MAX_BONDS (MAX_BONDS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .addr_i             (addr),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .basis_state_i      (basis_state_i),
    .site_i             (site_i),
    .bond_slot_i        (bond_slot_i),
    .bond_first_site_i  (bond_first_site_i),
    .bond_second_site_i (bond_second_site_i),
    .bond_coupling_i    (bond_coupling_i),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .row_o              (row_o),
    .column_o           (column_o),
    .delta_o            (delta_o),
    .last_o             (last_o)
  );

endmodule
